// ===== rtl/core/fm0r_pkg.sv =====
// ----------------------------------------------------------------------------
// FM0 edge frame receiver package
// Register indexes, reset values and the result beat type shared by the
// receiver RTL.
// ----------------------------------------------------------------------------
package fm0r_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_BIT_PERIOD      = 3'd0;
    localparam logic [2:0] REG_EARLY_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_LATE_TOLERANCE  = 3'd2;
    localparam logic [2:0] REG_PREAMBLE        = 3'd3;
    localparam logic [2:0] REG_DELIMITER       = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int INTERVAL_W  = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int BYTE_CNT_W  = 5;

    // Register values after reset.
    localparam logic [15:0] RST_BIT_PERIOD      = 16'd1000;
    localparam logic [15:0] RST_EARLY_TOLERANCE = 16'd50;
    localparam logic [15:0] RST_LATE_TOLERANCE  = 16'd50;
    localparam logic [7:0]  RST_PREAMBLE        = 8'hAA;
    localparam logic [7:0]  RST_DELIMITER       = 8'h7E;

    // Bits in one complete byte and the bit count ceiling while hunting.
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_MAX   = 4'd15;

    // One result beat.
    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
        logic              preamble_hit;
        logic              in_frame;
    } t_result;

endpackage

// ===== rtl/core/fm0_edge_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// FM0 edge frame receiver
// Classifies edge intervals of an FM0 line into bits, hunts for a start
// delimiter and emits the bytes of fixed-length frames.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one edge interval per beat (i_valid, o_stall,
// i_edge_interval). A beat is taken at a clock edge with i_valid high and
// o_stall low. The output channel returns exactly one result beat per input
// beat (o_valid, i_stall and the five result fields), in order.
// Each beat is decoded combinationally and registered into the output register,
// or into the skid register while the output is stalled. One beat per cycle is
// sustained unless the output stalls; the rate is set by the decode of
// the interval classifier and the bit shifter update, a loop closed on itself.
// When the receiver stalls, a result waiting on the output is held and one
// more beat is taken into a skid register; o_stall then rises until the
// output drains. o_stall is driven from a register only. Configuration must
// be written through i_cfg_we, i_cfg_index and i_cfg_data by the user while
// the block is idle (not enforced by the block); unknown indexes are ignored.
// A synchronous reset (i_rst_n low) restores the register defaults, returns
// the decoder to hunting and empties the output and skid registers.
// ----------------------------------------------------------------------------
module fm0_edge_frame_receiver_top #(
    parameter int FRAME_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [fm0r_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fm0r_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fm0r_pkg::INTERVAL_W-1:0]  i_edge_interval,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_byte_valid,
    output logic [fm0r_pkg::BYTE_W-1:0]      o_frame_byte,
    output logic                           o_frame_end,
    output logic                           o_preamble_hit,
    output logic                           o_in_frame
);

    import fm0r_pkg::*;

    localparam logic [BYTE_CNT_W-1:0] FRAME_LEN = BYTE_CNT_W'(FRAME_BYTES);

    // Configuration registers.
    logic [15:0] r_bit_period;
    logic [15:0] r_early_tol;
    logic [15:0] r_late_tol;
    logic [7:0]  r_preamble;
    logic [7:0]  r_delimiter;

    // Decoder state.
    logic                  r_capturing,   n_capturing;
    logic                  r_half_zero,   n_half_zero;
    logic [BYTE_W-1:0]     r_shifter,     n_shifter;
    logic [BIT_CNT_W-1:0]  r_bit_cnt,     n_bit_cnt;
    logic [BYTE_CNT_W-1:0] r_byte_cnt,    n_byte_cnt;

    // Output and skid registers.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    t_result n_result;
    logic    in_take;
    logic    out_take;

    // Interval thresholds.
    logic [14:0] half_bit;
    logic [15:0] three_q;
    logic [15:0] low_bound;
    logic [16:0] high_bound;
    logic        is_half_zero;
    logic        is_one;

    assign in_take  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= RST_BIT_PERIOD;
            r_early_tol  <= RST_EARLY_TOLERANCE;
            r_late_tol   <= RST_LATE_TOLERANCE;
            r_preamble   <= RST_PREAMBLE;
            r_delimiter  <= RST_DELIMITER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BIT_PERIOD:      r_bit_period <= i_cfg_data;
                REG_EARLY_TOLERANCE: r_early_tol  <= i_cfg_data;
                REG_LATE_TOLERANCE:  r_late_tol   <= i_cfg_data;
                REG_PREAMBLE:        r_preamble   <= i_cfg_data[7:0];
                REG_DELIMITER:       r_delimiter  <= i_cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // Thresholds derived from the bit period and the tolerances.
    always_comb begin
        half_bit   = r_bit_period[15:1];
        three_q    = r_bit_period - {2'b00, r_bit_period[15:2]};
        low_bound  = (r_early_tol >= {1'b0, half_bit}) ? 16'd0
                                                      : {1'b0, half_bit} - r_early_tol;
        high_bound = {1'b0, r_bit_period} + {1'b0, r_late_tol};
        is_half_zero = (i_edge_interval >= low_bound) && (i_edge_interval < three_q);
        is_one       = (i_edge_interval >= three_q)
                    && ({1'b0, i_edge_interval} <= high_bound);
    end

    // Bit decode, delimiter hunt and frame byte counting for one interval.
    always_comb begin
        n_capturing = r_capturing;
        n_half_zero = r_half_zero;
        n_shifter   = r_shifter;
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_result    = '0;

        // Interval classification and bit shifting.
        if (is_half_zero) begin
            if (!r_half_zero) begin
                n_half_zero = 1'b1;
            end else begin
                n_half_zero = 1'b0;
                n_shifter   = {r_shifter[BYTE_W-2:0], 1'b0};
                if (r_bit_cnt < BIT_CNT_MAX) begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                end
            end
        end else if (is_one) begin
            n_half_zero = 1'b0;
            n_shifter   = {r_shifter[BYTE_W-2:0], 1'b1};
            if (r_bit_cnt < BIT_CNT_MAX) begin
                n_bit_cnt = r_bit_cnt + 1'b1;
            end
        end else begin
            n_half_zero = 1'b0;
            n_shifter   = '0;
            n_bit_cnt   = '0;
        end

        // Hunting compares the shifter to both patterns; capturing emits bytes.
        if (!r_capturing) begin
            n_result.preamble_hit = (n_shifter == r_preamble);
            if (n_shifter == r_delimiter) begin
                n_result.byte_valid = 1'b1;
                n_result.frame_byte = n_shifter;
                n_bit_cnt   = '0;
                n_byte_cnt  = r_byte_cnt + 1'b1;
                n_shifter   = '0;
                n_capturing = 1'b1;
            end
        end else begin
            if (n_bit_cnt == BITS_PER_BYTE) begin
                n_result.byte_valid = 1'b1;
                n_result.frame_byte = n_shifter;
                n_bit_cnt  = '0;
                n_byte_cnt = r_byte_cnt + 1'b1;
                n_shifter  = '0;
            end
            if (n_byte_cnt >= FRAME_LEN) begin
                n_byte_cnt  = '0;
                n_capturing = 1'b0;
                n_result.frame_end = n_result.byte_valid;
            end
        end

        n_result.in_frame = n_capturing;
    end

    // Decoder state update on each taken beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_half_zero <= 1'b0;
            r_shifter   <= '0;
            r_bit_cnt   <= '0;
            r_byte_cnt  <= '0;
        end else if (in_take) begin
            r_capturing <= n_capturing;
            r_half_zero <= n_half_zero;
            r_shifter   <= n_shifter;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_cnt  <= n_byte_cnt;
        end
    end

    // Output register with a one-beat skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_take;
                end
            end else if (in_take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payload follows the same steering as the valid flags.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_take) begin
                r_out <= n_result;
            end
        end else if (in_take) begin
            r_skid <= n_result;
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_byte_valid   = r_out.byte_valid;
    assign o_frame_byte   = r_out.frame_byte;
    assign o_frame_end    = r_out.frame_end;
    assign o_preamble_hit = r_out.preamble_hit;
    assign o_in_frame     = r_out.in_frame;

    // The skid register only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output is empty");

    // A beat taken while the output is stalled lands in the skid register.
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("beat taken under output stall was not kept");

    // The last byte of a frame is a real byte and closes the frame.
    a_end_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.byte_valid && !r_out.in_frame))
        else $error("frame end without a byte or with capture still open");

    // No byte value is shown when no byte is emitted.
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |-> (r_out.frame_byte == '0))
        else $error("frame byte is nonzero without a byte beat");

    // The frame byte count stays below the frame length between beats.
    a_byte_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt < FRAME_LEN)
        else $error("frame byte count reached the frame length");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FM0 edge frame receiver testbench
// Streams edge intervals into the receiver through a queue-fed driver and
// checks every result beat against a cycle-free model of the FM0 decoder.
// A directed opening probes the classifier bounds. It is followed by phases
// of well-formed preamble, delimiter and payload sequences with some noise.
// Each phase uses its own register setting and its own idling pattern.
// ----------------------------------------------------------------------------
module tb;
    import fm0r_pkg::*;

    localparam int FRAME_LEN      = 16;
    localparam int RANDOM_ITEMS   = 700;
    localparam int DIRECTED_ITEMS = 21;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 100;
    localparam int unsigned INTERVAL_MAX = 65535;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // DUT ports.
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   i_valid         = 1'b0;
    logic                   o_stall;
    logic [INTERVAL_W-1:0]  i_edge_interval = '0;
    logic                   o_valid;
    logic                   i_stall         = 1'b0;
    logic                   o_byte_valid;
    logic [BYTE_W-1:0]      o_frame_byte;
    logic                   o_frame_end;
    logic                   o_preamble_hit;
    logic                   o_in_frame;

    // Register shadow and the classifier bounds derived from it.
    logic [15:0]  cfg_bit_period = RST_BIT_PERIOD;
    logic [15:0]  cfg_early_tol  = RST_EARLY_TOLERANCE;
    logic [15:0]  cfg_late_tol   = RST_LATE_TOLERANCE;
    logic [7:0]   cfg_preamble   = RST_PREAMBLE;
    logic [7:0]   cfg_delimiter  = RST_DELIMITER;
    int unsigned  lim_half_lo;
    int unsigned  lim_one_lo;
    int unsigned  lim_one_hi;

    // Decoder state as the model sees it.
    logic                  dec_capturing    = 1'b0;
    logic                  dec_half_pending = 1'b0;
    logic [BYTE_W-1:0]     dec_shifter      = '0;
    logic [BIT_CNT_W-1:0]  dec_bit_cnt      = '0;
    logic [BYTE_CNT_W-1:0] dec_byte_cnt     = '0;

    // Intervals waiting to be sent and result beats waiting to arrive.
    logic [INTERVAL_W-1:0] edge_intervals[$];
    t_result               pending_results[$];
    t_result               oldest_result;

    // Idling control shared between the stimulus and the two channel processes.
    int  send_gap_max  = 0;
    int  recv_gap_max  = 0;
    int  send_wait     = 0;
    int  recv_wait     = 0;
    int  hold_left     = 0;
    bit  hold_toggle   = 1'b0;
    bit  hold_seen     = 1'b0;
    int  beats_sent    = 0;
    int  mismatch_count = 0;
    int  idle_cycles   = 0;

    fm0_edge_frame_receiver_top #(
        .FRAME_BYTES(FRAME_LEN)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_edge_interval(i_edge_interval),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_valid   (o_byte_valid),
        .o_frame_byte   (o_frame_byte),
        .o_frame_end    (o_frame_end),
        .o_preamble_hit (o_preamble_hit),
        .o_in_frame     (o_in_frame)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s, expected %0h, got %0h", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    // Recompute the half-zero and one windows from the register shadow.
    task automatic set_bounds();
        int unsigned bp;
        int unsigned half;
        bp   = 32'(cfg_bit_period);
        half = bp >> 1;
        lim_half_lo = (cfg_early_tol >= half) ? 0 : half - cfg_early_tol;
        lim_one_lo  = bp - (bp >> 2);
        lim_one_hi  = bp + cfg_late_tol;
    endtask

    // Advance the decoder model by one interval and return its result beat.
    function automatic t_result decode_interval(input logic [INTERVAL_W-1:0] t);
        t_result r;
        logic    have_bit;
        logic    bit_val;
        r        = '0;
        have_bit = 1'b0;
        bit_val  = 1'b0;

        // Classify the interval.
        if (t >= lim_half_lo && t < lim_one_lo) begin
            if (!dec_half_pending) begin
                dec_half_pending = 1'b1;
            end else begin
                dec_half_pending = 1'b0;
                have_bit = 1'b1;
            end
        end else if (t >= lim_one_lo && t <= lim_one_hi) begin
            dec_half_pending = 1'b0;
            have_bit = 1'b1;
            bit_val  = 1'b1;
        end else begin
            dec_half_pending = 1'b0;
            dec_shifter = '0;
            dec_bit_cnt = '0;
        end

        // Shift in the decoded bit; the count saturates while hunting.
        if (have_bit) begin
            dec_shifter = {dec_shifter[BYTE_W-2:0], bit_val};
            if (dec_bit_cnt < BIT_CNT_MAX) begin
                dec_bit_cnt++;
            end
        end

        if (!dec_capturing) begin
            // Hunting: look for the preamble and the start delimiter.
            if (dec_shifter == cfg_preamble) begin
                r.preamble_hit = 1'b1;
            end
            if (dec_shifter == cfg_delimiter) begin
                r.byte_valid  = 1'b1;
                r.frame_byte  = dec_shifter;
                dec_bit_cnt   = '0;
                dec_byte_cnt  = dec_byte_cnt + 1'b1;
                dec_shifter   = '0;
                dec_capturing = 1'b1;
            end
        end else begin
            // Capturing: emit each full byte and close the frame at its length.
            if (dec_bit_cnt == BITS_PER_BYTE) begin
                r.byte_valid = 1'b1;
                r.frame_byte = dec_shifter;
                dec_bit_cnt  = '0;
                dec_byte_cnt = dec_byte_cnt + 1'b1;
                dec_shifter  = '0;
            end
            if (dec_byte_cnt >= FRAME_LEN) begin
                dec_byte_cnt  = '0;
                dec_capturing = 1'b0;
                r.frame_end   = r.byte_valid;
            end
        end

        r.in_frame = dec_capturing;
        return r;
    endfunction

    // Input driver: offers queued intervals and predicts each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_results.push_back(decode_interval(i_edge_interval));
                beats_sent++;
                send_wait = $urandom_range(0, send_gap_max);
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (edge_intervals.size() > 0) begin
                    i_valid         <= 1'b1;
                    i_edge_interval <= edge_intervals.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result beat and drives the receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 0, 1);
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (o_byte_valid !== oldest_result.byte_valid)
                        report_mismatch("byte_valid", 32'(oldest_result.byte_valid),
                                        32'(o_byte_valid));
                    if (o_frame_byte !== oldest_result.frame_byte)
                        report_mismatch("frame_byte", 32'(oldest_result.frame_byte),
                                        32'(o_frame_byte));
                    if (o_frame_end !== oldest_result.frame_end)
                        report_mismatch("frame_end", 32'(oldest_result.frame_end),
                                        32'(o_frame_end));
                    if (o_preamble_hit !== oldest_result.preamble_hit)
                        report_mismatch("preamble_hit", 32'(oldest_result.preamble_hit),
                                        32'(o_preamble_hit));
                    if (o_in_frame !== oldest_result.in_frame)
                        report_mismatch("in_frame", 32'(oldest_result.in_frame),
                                        32'(o_in_frame));
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end

            // A long hold-off is requested by flipping hold_toggle.
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("fm0_edge_frame_receiver_top verification failed");
                $finish;
            end
        end
    end

    // Pick a value in a window, with extra weight on both ends.
    function automatic logic [INTERVAL_W-1:0] pick_in(input int unsigned lo,
                                                     input int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return INTERVAL_W'(lo);
            1:       return INTERVAL_W'(hi);
            default: return INTERVAL_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Push a decoder-clearing interval, if the current windows leave room for one.
    task automatic push_bad();
        if (lim_half_lo > 0 && (lim_one_hi >= INTERVAL_MAX || $urandom_range(0, 1))) begin
            edge_intervals.push_back(pick_in(0, lim_half_lo - 1));
        end else if (lim_one_hi < INTERVAL_MAX) begin
            edge_intervals.push_back(pick_in(lim_one_hi + 1, INTERVAL_MAX));
        end
    endtask

    // A one is a single full interval; a zero is two half intervals.
    task automatic push_bit(input logic b);
        int unsigned one_top;
        one_top = (lim_one_hi > INTERVAL_MAX) ? INTERVAL_MAX : lim_one_hi;
        if (b) begin
            edge_intervals.push_back(pick_in(lim_one_lo, one_top));
        end else begin
            repeat (2) edge_intervals.push_back(pick_in(lim_half_lo, lim_one_lo - 1));
        end
    endtask

    // Send a byte MSB first, now and then with a stray interval between bits.
    task automatic push_byte(input logic [7:0] value);
        for (int i = 7; i >= 0; i--) begin
            if ($urandom_range(0, 31) == 0) begin
                if ($urandom_range(0, 1)) begin
                    edge_intervals.push_back(INTERVAL_W'($urandom_range(0, INTERVAL_MAX)));
                end else begin
                    push_bad();
                end
            end
            push_bit(value[i]);
        end
    endtask

    // One frame attempt: sync, optional preamble, delimiter, payload, noisy tail.
    task automatic push_frame_attempt();
        int payload_bytes;
        payload_bytes = $urandom_range(0, 1) ? FRAME_LEN - 1 : $urandom_range(0, FRAME_LEN - 1);
        push_bad();
        if ($urandom_range(0, 1)) begin
            push_byte(cfg_preamble);
        end
        push_byte(cfg_delimiter);
        repeat (payload_bytes) push_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4))
            edge_intervals.push_back(INTERVAL_W'($urandom_range(0, INTERVAL_MAX)));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            REG_BIT_PERIOD:      cfg_bit_period = data;
            REG_EARLY_TOLERANCE: cfg_early_tol  = data;
            REG_LATE_TOLERANCE:  cfg_late_tol   = data;
            REG_PREAMBLE:        cfg_preamble   = data[7:0];
            REG_DELIMITER:       cfg_delimiter  = data[7:0];
            default: ;
        endcase
    endtask

    // Write all five registers; pattern writes carry junk in the upper byte.
    task automatic write_config(input logic [15:0] bp, input logic [15:0] early,
                                input logic [15:0] late, input logic [7:0] pre,
                                input logic [7:0] delim);
        write_reg(REG_BIT_PERIOD, bp);
        write_reg(REG_EARLY_TOLERANCE, early);
        write_reg(REG_LATE_TOLERANCE, late);
        write_reg(REG_PREAMBLE, {8'($urandom_range(0, 255)), pre});
        write_reg(REG_DELIMITER, {8'($urandom_range(0, 255)), delim});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        set_bounds();
    endtask

    // Block until the sender is empty and every result beat has been checked.
    task automatic wait_idle();
        while (edge_intervals.size() != 0 || i_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus sequencing.
    initial begin : stimulus
        int          phase;
        logic [15:0] new_bp;
        logic [15:0] new_early;
        logic [15:0] new_late;
        logic [7:0]  new_pre;
        logic [7:0]  new_del;

        set_bounds();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at reset values: field extremes and window edges,
        // then a bad interval and the preamble byte.
        @(negedge i_clk);
        edge_intervals.push_back(16'd0);
        edge_intervals.push_back(16'hFFFF);
        edge_intervals.push_back(16'(lim_half_lo - 1));
        edge_intervals.push_back(16'(lim_half_lo));
        edge_intervals.push_back(16'(lim_one_lo - 1));
        edge_intervals.push_back(16'(lim_one_lo));
        edge_intervals.push_back(16'(lim_one_hi));
        edge_intervals.push_back(16'(lim_one_hi + 1));
        push_bad();
        push_byte(cfg_preamble);
        wait_idle();

        phase = 0;
        while (beats_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    write_reg(REG_UNUSED, 16'hFFFF);
                    write_config(RST_BIT_PERIOD, RST_EARLY_TOLERANCE, RST_LATE_TOLERANCE,
                                 RST_PREAMBLE, RST_DELIMITER);
                end
                1: write_config(16'd4, 16'd0, 16'd0, 8'h00, 8'hFF);
                2: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00);
                3: write_config(16'd1001, 16'd700, 16'd3, 8'h5A, 8'h5A);
                default: begin
                    new_bp    = 16'($urandom_range(0, 1) ? $urandom_range(4, 80)
                                                         : $urandom_range(4, INTERVAL_MAX));
                    new_early = 16'(($urandom_range(0, 3) == 0)
                                    ? $urandom_range(0, INTERVAL_MAX)
                                    : $urandom_range(0, new_bp / 4));
                    new_late  = 16'(($urandom_range(0, 3) == 0)
                                    ? $urandom_range(0, INTERVAL_MAX)
                                    : $urandom_range(0, new_bp / 4));
                    new_pre   = 8'($urandom_range(0, 255));
                    new_del   = ($urandom_range(0, 3) == 0) ? new_pre
                                                            : 8'($urandom_range(0, 255));
                    write_config(new_bp, new_early, new_late, new_pre, new_del);
                end
            endcase

            // Idling pattern for this phase; some phases run with no gaps.
            @(negedge i_clk);
            case ($urandom_range(0, 2))
                0:       send_gap_max = 0;
                1:       send_gap_max = 17;
                default: send_gap_max = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 2))
                0:       recv_gap_max = 0;
                1:       recv_gap_max = 17;
                default: recv_gap_max = $urandom_range(1, 6);
            endcase

            // Back the output up while the sender streams, so the input stalls.
            if (phase == 1) begin
                send_gap_max = 0;
                hold_toggle  = !hold_toggle;
            end

            push_frame_attempt();
            if ($urandom_range(0, 1)) begin
                push_frame_attempt();
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("fm0_edge_frame_receiver_top verification clean");
        end else begin
            $display("fm0_edge_frame_receiver_top verification failed");
        end
        $finish;
    end

endmodule
